@@ src/jcmp_pkg.sv @@
`timescale 1ns / 1ps
package jcmp_pkg;

  localparam int PositionWidth = 32;

  localparam logic [15:0] M_SOC = 16'hff4f;
  localparam logic [15:0] M_SOT = 16'hff90;
  localparam logic [15:0] M_SOD = 16'hff93;
  localparam logic [15:0] M_EOC = 16'hffd9;
  localparam logic [15:0] M_EPH = 16'hff92;
  localparam logic [15:0] M_SIZ = 16'hff51;
  localparam logic [15:0] M_COD = 16'hff52;
  localparam logic [15:0] M_QCD = 16'hff5c;
  localparam logic [15:0] M_TLM = 16'hff55;
  localparam logic [15:0] M_COM = 16'hff64;

  typedef enum logic [2:0] {
    PH_MARK_HI = 3'd0,
    PH_MARK_LO = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_BODY    = 3'd4,
    PH_SKIP    = 3'd5,
    PH_FOREVER = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_MARK_HI = 3'd0,
    ROLE_MARK_LO = 3'd1,
    ROLE_LENGTH  = 3'd2,
    ROLE_BODY    = 3'd3,
    ROLE_TILE    = 3'd4,
    ROLE_IGNORED = 3'd5
  } role_t;

  localparam logic [3:0] E_NONE     = 4'd0;
  localparam logic [3:0] E_MARKER   = 4'd1;
  localparam logic [3:0] E_NO_SOC   = 4'd2;
  localparam logic [3:0] E_LEN      = 4'd3;
  localparam logic [3:0] E_SOT_LEN  = 4'd4;
  localparam logic [3:0] E_PSOT     = 4'd5;
  localparam logic [3:0] E_TPSOT    = 4'd6;
  localparam logic [3:0] E_SIZ_LEN  = 4'd7;
  localparam logic [3:0] E_SIZ_CSIZ = 4'd8;
  localparam logic [3:0] E_COD_LEN  = 4'd9;
  localparam logic [3:0] E_QCD_LEN  = 4'd10;
  localparam logic [3:0] E_TLM_LEN  = 4'd11;
  localparam logic [3:0] E_TLM_ST   = 4'd12;
  localparam logic [3:0] E_TLM_DIV  = 4'd13;
  localparam logic [3:0] E_COM_LEN  = 4'd14;
  localparam logic [3:0] E_PAST     = 4'd15;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [15:0] marker_code;
    logic [3:0]  error_code;
    logic        frame_end;
    logic [31:0] frame_total;
    logic [15:0] tile_part_number;
  } result_t;

endpackage

@@ src/jcmp_byte_if.sv @@
`timescale 1ns / 1ps
interface jcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ src/jcmp_result_if.sv @@
`timescale 1ns / 1ps
interface jcmp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [15:0] marker_code;
  logic [3:0]  error_code;
  logic        frame_end;
  logic [31:0] frame_total;
  logic [15:0] tile_part_number;
  modport source (output valid, output byte_role, output marker_code, output error_code,
                  output frame_end, output frame_total, output tile_part_number,
                  input ready);
  modport sink (input valid, input byte_role, input marker_code, input error_code,
                input frame_end, input frame_total, input tile_part_number,
                output ready);
endinterface

@@ src/jcmp_parse_core.sv @@
`timescale 1ns / 1ps
module jcmp_parse_core #(
  parameter int POSITION_WIDTH = jcmp_pkg::PositionWidth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  output jcmp_pkg::result_t   result
);

  // Compare Psot and the byte position at one bit more than the wider of the two widths.
  localparam int ExtWidth = (POSITION_WIDTH > 32) ? POSITION_WIDTH + 1 : 33;

  jcmp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] marker_r, marker_nxt;
  logic [15:0] seglen_r, seglen_nxt;
  logic [15:0] bpos_r, bpos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] psot_r, psot_nxt;
  logic [POSITION_WIDTH-1:0] since_r, since_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [2:0]  tlm_ph_r, tlm_ph_nxt;
  logic        expect_r, expect_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [15:0] tparts_r, tparts_nxt;
  logic [3:0]  lerr_r, lerr_nxt;

  logic [15:0] m_lo, len_lo;
  logic [3:0]  err;
  logic [2:0]  role;
  logic        fend, last, alone;
  logic [2:0]  esz, tph_inc;
  logic [ExtWidth-1:0] psot_ext, since_ext, rem;
  logic [15:0] siz_lhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jcmp_pkg::PH_MARK_HI;
      marker_r <= '0;
      seglen_r <= '0;
      bpos_r   <= '0;
      shift_r  <= '0;
      psot_r   <= '0;
      since_r  <= '0;
      skip_r   <= '0;
      tlm_ph_r <= '0;
      expect_r <= 1'b1;
      frames_r <= '0;
      tparts_r <= '0;
      lerr_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      marker_r <= marker_nxt;
      seglen_r <= seglen_nxt;
      bpos_r   <= bpos_nxt;
      shift_r  <= shift_nxt;
      psot_r   <= psot_nxt;
      since_r  <= since_nxt;
      skip_r   <= skip_nxt;
      tlm_ph_r <= tlm_ph_nxt;
      expect_r <= expect_nxt;
      frames_r <= frames_nxt;
      tparts_r <= tparts_nxt;
      lerr_r   <= lerr_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    seglen_nxt = seglen_r;
    bpos_nxt   = bpos_r;
    shift_nxt  = shift_r;
    psot_nxt   = psot_r;
    since_nxt  = since_r;
    skip_nxt   = skip_r;
    tlm_ph_nxt = tlm_ph_r;
    expect_nxt = expect_r;
    frames_nxt = frames_r;
    tparts_nxt = tparts_r;
    lerr_nxt   = lerr_r;
    err  = jcmp_pkg::E_NONE;
    role = jcmp_pkg::ROLE_IGNORED;
    fend = 1'b0;
    m_lo   = {marker_r[15:8], data_byte};
    len_lo = {seglen_r[15:8], data_byte};
    alone  = (m_lo >= 16'hff30 && m_lo <= 16'hff3f) || m_lo == jcmp_pkg::M_SOC ||
             m_lo == jcmp_pkg::M_EOC || m_lo == jcmp_pkg::M_SOD ||
             m_lo == jcmp_pkg::M_EPH;
    last = ((bpos_r + 16'd1) == (seglen_r - 16'd2));
    esz  = {1'b0, shift_r[5:4]} + ({2'b0, shift_r[6]} + 3'd1) * 3'd2;
    tph_inc = tlm_ph_r + 3'd1;
    psot_ext  = ExtWidth'(psot_r);
    since_ext = ExtWidth'(since_r + POSITION_WIDTH'(1));
    rem = psot_ext - since_ext;
    siz_lhs = seglen_r - 16'd38;

    if (phase_r != jcmp_pkg::PH_HALT) begin
      since_nxt = since_r + POSITION_WIDTH'(1);
      case (phase_r)
        jcmp_pkg::PH_FOREVER: role = jcmp_pkg::ROLE_TILE;
        jcmp_pkg::PH_SKIP: begin
          role = jcmp_pkg::ROLE_TILE;
          if (skip_r <= 32'd1) begin
            skip_nxt   = '0;
            tparts_nxt = tparts_r + 16'd1;
            phase_nxt  = jcmp_pkg::PH_MARK_HI;
          end else begin
            skip_nxt = skip_r - 32'd1;
          end
        end
        jcmp_pkg::PH_MARK_HI: begin
          role       = jcmp_pkg::ROLE_MARK_HI;
          marker_nxt = {data_byte, 8'h00};
          phase_nxt  = jcmp_pkg::PH_MARK_LO;
        end
        jcmp_pkg::PH_MARK_LO: begin
          role       = jcmp_pkg::ROLE_MARK_LO;
          marker_nxt = m_lo;
          if (m_lo[15:8] != 8'hff || data_byte == 8'h00 || data_byte == 8'hff) begin
            err = jcmp_pkg::E_MARKER;
          end else if (expect_r && m_lo != jcmp_pkg::M_SOC) begin
            err = jcmp_pkg::E_NO_SOC;
          end else begin
            if (m_lo == jcmp_pkg::M_SOC) expect_nxt = 1'b0;
            if (alone) begin
              phase_nxt = jcmp_pkg::PH_MARK_HI;
              if (m_lo == jcmp_pkg::M_SOD) begin
                if (psot_ext >= since_ext) begin
                  if (rem != '0) begin
                    skip_nxt  = rem[31:0];
                    phase_nxt = jcmp_pkg::PH_SKIP;
                  end else begin
                    tparts_nxt = tparts_r + 16'd1;
                  end
                end else if (psot_r != '0) begin
                  err = jcmp_pkg::E_PAST;
                end else begin
                  phase_nxt = jcmp_pkg::PH_FOREVER;
                end
              end else if (m_lo == jcmp_pkg::M_EOC) begin
                frames_nxt = frames_r + 32'd1;
                fend       = 1'b1;
                expect_nxt = 1'b1;
                psot_nxt   = '0;
                tparts_nxt = '0;
              end
            end else begin
              if (m_lo == jcmp_pkg::M_SOT) since_nxt = POSITION_WIDTH'(2);
              phase_nxt = jcmp_pkg::PH_LEN_HI;
            end
          end
        end
        jcmp_pkg::PH_LEN_HI: begin
          role       = jcmp_pkg::ROLE_LENGTH;
          seglen_nxt = {data_byte, 8'h00};
          phase_nxt  = jcmp_pkg::PH_LEN_LO;
        end
        jcmp_pkg::PH_LEN_LO: begin
          role       = jcmp_pkg::ROLE_LENGTH;
          seglen_nxt = len_lo;
          if (len_lo < 16'd2) err = jcmp_pkg::E_LEN;
          else if (marker_r == jcmp_pkg::M_SOT && len_lo != 16'd10) err = jcmp_pkg::E_SOT_LEN;
          else if (marker_r == jcmp_pkg::M_SIZ && len_lo < 16'd38) err = jcmp_pkg::E_SIZ_LEN;
          else if (marker_r == jcmp_pkg::M_COD && len_lo < 16'd12) err = jcmp_pkg::E_COD_LEN;
          else if (marker_r == jcmp_pkg::M_QCD && len_lo == 16'd2) err = jcmp_pkg::E_QCD_LEN;
          else if (marker_r == jcmp_pkg::M_TLM && len_lo < 16'd6) err = jcmp_pkg::E_TLM_LEN;
          else if (marker_r == jcmp_pkg::M_COM && len_lo == 16'd2) err = jcmp_pkg::E_COM_LEN;
          if (err == jcmp_pkg::E_NONE) begin
            if (len_lo == 16'd2) begin
              phase_nxt = jcmp_pkg::PH_MARK_HI;
            end else begin
              phase_nxt  = jcmp_pkg::PH_BODY;
              bpos_nxt   = '0;
              shift_nxt  = '0;
              tlm_ph_nxt = '0;
            end
          end
        end
        jcmp_pkg::PH_BODY: begin
          role = jcmp_pkg::ROLE_BODY;
          if (!(marker_r == jcmp_pkg::M_TLM && bpos_r >= 16'd2))
            shift_nxt = {shift_r[23:0], data_byte};
          if (marker_r == jcmp_pkg::M_SOT) begin
            if (bpos_r == 16'd5) begin
              psot_nxt = shift_nxt;
              if (shift_nxt != '0 && shift_nxt < 32'd14) err = jcmp_pkg::E_PSOT;
            end else if (bpos_r == 16'd6 && data_byte == 8'hff) begin
              err = jcmp_pkg::E_TPSOT;
            end
          end else if (marker_r == jcmp_pkg::M_SIZ) begin
            if (bpos_r == 16'd35 && 18'(siz_lhs) != 18'(shift_nxt[15:0]) * 18'd3)
              err = jcmp_pkg::E_SIZ_CSIZ;
          end else if (marker_r == jcmp_pkg::M_TLM) begin
            if (bpos_r == 16'd1) begin
              if (data_byte[5:4] == 2'd3) err = jcmp_pkg::E_TLM_ST;
              tlm_ph_nxt = '0;
            end else if (bpos_r >= 16'd2) begin
              tlm_ph_nxt = (tph_inc >= esz) ? 3'd0 : tph_inc;
              if (last && tlm_ph_nxt != 3'd0) err = jcmp_pkg::E_TLM_DIV;
            end
          end
          if (last) phase_nxt = jcmp_pkg::PH_MARK_HI;
          else bpos_nxt = bpos_r + 16'd1;
        end
        default: phase_nxt = jcmp_pkg::PH_HALT;
      endcase
      if (err != jcmp_pkg::E_NONE) begin
        lerr_nxt  = err;
        phase_nxt = jcmp_pkg::PH_HALT;
      end
    end

    result.byte_role        = role;
    result.marker_code      = marker_nxt;
    result.error_code       = (err != jcmp_pkg::E_NONE) ? err : lerr_r;
    result.frame_end        = fend;
    result.frame_total      = frames_nxt;
    result.tile_part_number = tparts_nxt;
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == jcmp_pkg::PH_HALT |=> phase_r == jcmp_pkg::PH_HALT)
    else $error("halt left");
  a_halt_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == jcmp_pkg::PH_HALT |-> lerr_r != jcmp_pkg::E_NONE)
    else $error("halt without error");
  a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
    lerr_r != jcmp_pkg::E_NONE |=> $stable(lerr_r))
    else $error("error changed");
`endif

endmodule

@@ src/j2k_codestream_marker_parser.sv @@
`timescale 1ns / 1ps
// JPEG 2000 codestream marker parser: takes one codestream byte per beat and
// returns one labeled result beat per byte (role, marker, error, frame end,
// frame count, tile part number). One byte per cycle sustained while the
// output is not stalled: the parse state updates as each byte is taken and
// the result sits in an output register that refills in the same cycle it
// drains. The first error halts parsing until reset; later bytes return role 5.
module j2k_codestream_marker_parser #(
  parameter int POSITION_WIDTH = jcmp_pkg::PositionWidth
) (
  input  logic clk,
  input  logic rst_n,
  jcmp_byte_if.sink     in_ch,
  jcmp_result_if.source out_ch
);

  jcmp_pkg::result_t res, res_r;
  logic out_valid_r, step;

  // Accept whenever the output register is empty or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  jcmp_parse_core #(.POSITION_WIDTH(POSITION_WIDTH)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .data_byte(in_ch.data_byte), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // Hold the payload while a beat waits.
  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.byte_role        = res_r.byte_role;
  assign out_ch.marker_code      = res_r.marker_code;
  assign out_ch.error_code       = res_r.error_code;
  assign out_ch.frame_end        = res_r.frame_end;
  assign out_ch.frame_total      = res_r.frame_total;
  assign out_ch.tile_part_number = res_r.tile_part_number;

`ifndef ASSERT_OFF
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted byte lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(res_r))
    else $error("stalled result changed");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int WatchdogLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  jcmp_byte_if in_if ();
  jcmp_result_if out_if ();

  j2k_codestream_marker_parser u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  // Directed rows: a role/error typed in means that is the expected label;
  // the rest of the beat comes from the parser model.
  typedef struct {
    logic [7:0]       data;
    bit               typed;
    jcmp_pkg::role_t  role;
    logic [3:0]       err;
  } stim_row_t;

  typedef struct {
    bit               typed;
    jcmp_pkg::role_t  role;
    logic [3:0]       err;
  } label_t;

  // Parser model state
  jcmp_pkg::phase_t ph;
  logic [15:0] cur_marker, seg_len, body_pos, tile_parts;
  logic [31:0] field_sh, psot, since_sot, skip_left, frames;
  logic [2:0]  tlm_phase;
  bit          need_soc;
  logic [3:0]  err_latch;

  logic [7:0]         stream_q[$];
  label_t             label_q[$];
  jcmp_pkg::result_t  expected_q[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         tx_idle = 14;
  int         rx_idle = 88;

  function automatic logic [3:0] seg_len_error(logic [15:0] m, int unsigned len);
    if (len < 2) return jcmp_pkg::E_LEN;
    if (m == jcmp_pkg::M_SOT && len != 10) return jcmp_pkg::E_SOT_LEN;
    if (m == jcmp_pkg::M_SIZ && len < 38) return jcmp_pkg::E_SIZ_LEN;
    if (m == jcmp_pkg::M_COD && len < 12) return jcmp_pkg::E_COD_LEN;
    if (m == jcmp_pkg::M_QCD && len == 2) return jcmp_pkg::E_QCD_LEN;
    if (m == jcmp_pkg::M_TLM && len < 6) return jcmp_pkg::E_TLM_LEN;
    if (m == jcmp_pkg::M_COM && len == 2) return jcmp_pkg::E_COM_LEN;
    return jcmp_pkg::E_NONE;
  endfunction

  // Body byte of a length-carrying segment; returns the check error if any.
  function automatic logic [3:0] segment_body(logic [7:0] b);
    int unsigned p, len, st, esz, nph;
    logic [3:0] e;
    bit last;
    p = body_pos;
    len = seg_len;
    e = jcmp_pkg::E_NONE;
    last = (p + 1 == len - 2);
    if (!(cur_marker == jcmp_pkg::M_TLM && p >= 2)) field_sh = {field_sh[23:0], b};
    if (cur_marker == jcmp_pkg::M_SOT) begin
      if (p == 5) begin
        psot = field_sh;
        if (field_sh > 0 && field_sh < 14) e = jcmp_pkg::E_PSOT;
      end else if (p == 6 && b == 8'hff) begin
        e = jcmp_pkg::E_TPSOT;
      end
    end else if (cur_marker == jcmp_pkg::M_SIZ) begin
      if (p == 35 && (len - 38) != 3 * int'(field_sh[15:0])) e = jcmp_pkg::E_SIZ_CSIZ;
    end else if (cur_marker == jcmp_pkg::M_TLM) begin
      if (p == 1) begin
        if (b[5:4] == 2'd3) e = jcmp_pkg::E_TLM_ST;
        tlm_phase = '0;
      end else if (p >= 2) begin
        // element size from Stlm: ST bytes of Ttlm plus 2 or 4 of Ptlm
        st = field_sh[5:4];
        esz = st + 2 * (field_sh[6] + 1);
        nph = tlm_phase + 1;
        if (nph >= esz) nph = 0;
        tlm_phase = nph[2:0];
        if (last && nph != 0) e = jcmp_pkg::E_TLM_DIV;
      end
    end
    if (last) ph = jcmp_pkg::PH_MARK_HI;
    else body_pos = p + 1;
    return e;
  endfunction

  // SOD: skip the rest of the tile part, or drop into tile data for good; a passed Psot is an error.
  function automatic logic [3:0] enter_tile_data();
    if (psot >= since_sot) begin
      if (psot - since_sot > 0) begin
        skip_left = psot - since_sot;
        ph = jcmp_pkg::PH_SKIP;
      end else begin
        tile_parts++;
        ph = jcmp_pkg::PH_MARK_HI;
      end
      return jcmp_pkg::E_NONE;
    end
    if (psot > 0) return jcmp_pkg::E_PAST;
    ph = jcmp_pkg::PH_FOREVER;
    return jcmp_pkg::E_NONE;
  endfunction

  function automatic jcmp_pkg::result_t label_byte(logic [7:0] b);
    jcmp_pkg::result_t r;
    logic [3:0] e;
    logic [15:0] m;
    jcmp_pkg::role_t role;
    bit fend;
    role = jcmp_pkg::ROLE_IGNORED;
    e = jcmp_pkg::E_NONE;
    fend = 1'b0;
    if (ph != jcmp_pkg::PH_HALT) begin
      since_sot++;
      case (ph)
        jcmp_pkg::PH_FOREVER: role = jcmp_pkg::ROLE_TILE;
        jcmp_pkg::PH_SKIP: begin
          role = jcmp_pkg::ROLE_TILE;
          if (skip_left <= 1) begin
            skip_left = '0;
            tile_parts++;
            ph = jcmp_pkg::PH_MARK_HI;
          end else begin
            skip_left--;
          end
        end
        jcmp_pkg::PH_MARK_HI: begin
          role = jcmp_pkg::ROLE_MARK_HI;
          cur_marker = {b, 8'h00};
          ph = jcmp_pkg::PH_MARK_LO;
        end
        jcmp_pkg::PH_MARK_LO: begin
          m = {cur_marker[15:8], b};
          role = jcmp_pkg::ROLE_MARK_LO;
          cur_marker = m;
          if (m[15:8] != 8'hff || b == 8'h00 || b == 8'hff) begin
            e = jcmp_pkg::E_MARKER;
          end else if (need_soc && m != jcmp_pkg::M_SOC) begin
            e = jcmp_pkg::E_NO_SOC;
          end else begin
            if (m == jcmp_pkg::M_SOC) need_soc = 1'b0;
            if ((m >= 16'hff30 && m <= 16'hff3f) || m == jcmp_pkg::M_SOC ||
                m == jcmp_pkg::M_EOC || m == jcmp_pkg::M_SOD || m == jcmp_pkg::M_EPH) begin
              ph = jcmp_pkg::PH_MARK_HI;
              if (m == jcmp_pkg::M_SOD) begin
                e = enter_tile_data();
              end else if (m == jcmp_pkg::M_EOC) begin
                frames++;
                fend = 1'b1;
                need_soc = 1'b1;
                psot = '0;
                tile_parts = '0;
              end
            end else begin
              if (m == jcmp_pkg::M_SOT) since_sot = 32'd2;
              ph = jcmp_pkg::PH_LEN_HI;
            end
          end
        end
        jcmp_pkg::PH_LEN_HI: begin
          role = jcmp_pkg::ROLE_LENGTH;
          seg_len = {b, 8'h00};
          ph = jcmp_pkg::PH_LEN_LO;
        end
        jcmp_pkg::PH_LEN_LO: begin
          role = jcmp_pkg::ROLE_LENGTH;
          seg_len = {seg_len[15:8], b};
          e = seg_len_error(cur_marker, seg_len);
          if (e == jcmp_pkg::E_NONE) begin
            if (seg_len == 16'd2) begin
              ph = jcmp_pkg::PH_MARK_HI;
            end else begin
              ph = jcmp_pkg::PH_BODY;
              body_pos = '0;
              field_sh = '0;
              tlm_phase = '0;
            end
          end
        end
        jcmp_pkg::PH_BODY: begin
          role = jcmp_pkg::ROLE_BODY;
          e = segment_body(b);
        end
        default: ph = jcmp_pkg::PH_HALT;
      endcase
      if (e != jcmp_pkg::E_NONE) begin
        err_latch = e;
        ph = jcmp_pkg::PH_HALT;
      end
    end
    r.byte_role = role;
    r.marker_code = cur_marker;
    r.error_code = (e != jcmp_pkg::E_NONE) ? e : err_latch;
    r.frame_end = fend;
    r.frame_total = frames;
    r.tile_part_number = tile_parts;
    return r;
  endfunction

  // ---- codestream builders -------------------------------------------------

  task automatic put16(input logic [15:0] v);
    stream_q.push_back(v[15:8]);
    stream_q.push_back(v[7:0]);
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom));
  endtask

  task automatic put_sot(input logic [31:0] size, input logic [7:0] tp_idx);
    put16(jcmp_pkg::M_SOT);
    put16(16'd10);
    put_random(2);
    put16(size[31:16]);
    put16(size[15:0]);
    stream_q.push_back(tp_idx);
    put_random(1);
  endtask

  task automatic put_siz(input int comps, input int csiz_field);
    put16(jcmp_pkg::M_SIZ);
    put16(16'(38 + 3 * comps));
    for (int i = 0; i < 36 + 3 * comps; i++) begin
      if (i == 34) stream_q.push_back(8'(csiz_field >> 8));
      else if (i == 35) stream_q.push_back(8'(csiz_field));
      else stream_q.push_back(8'($urandom));
    end
  endtask

  task automatic put_tlm(input int st, input int elems);
    int esz;
    logic [7:0] stlm;
    stlm = 8'($urandom);
    stlm[5:4] = 2'(st);
    esz = st + 2 * (stlm[6] + 1);
    put16(jcmp_pkg::M_TLM);
    put16(16'(4 + elems * esz));
    put_random(1);
    stream_q.push_back(stlm);
    put_random(elems * esz);
  endtask

  // One well-formed frame: main header, one or two tile parts, EOC.
  task automatic put_frame();
    int comps, n, d;
    logic [7:0] others[5] = '{8'h53, 8'h5d, 8'h5e, 8'h60, 8'h63};
    comps = $urandom_range(1, 3);
    put16(jcmp_pkg::M_SOC);
    put_siz(comps, comps);
    n = $urandom_range(10, 14);
    put16(jcmp_pkg::M_COD); put16(16'(n + 2)); put_random(n);
    n = $urandom_range(1, 4);
    put16(jcmp_pkg::M_QCD); put16(16'(n + 2)); put_random(n);
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 6);
      put16(jcmp_pkg::M_COM); put16(16'(n + 2)); put_random(n);
    end
    if ($urandom_range(0, 1)) put_tlm($urandom_range(0, 2), $urandom_range(1, 3));
    if ($urandom_range(0, 1)) begin
      // unchecked segment, empty or with a body
      n = $urandom_range(0, 4);
      put16({8'hff, others[$urandom_range(0, 4)]}); put16(16'(n + 2)); put_random(n);
    end
    if ($urandom_range(0, 2) == 0) put16(16'hff30 + 16'($urandom_range(0, 15)));
    for (int t = $urandom_range(1, 2); t > 0; t--) begin
      d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      put_sot(32'(14 + d), 8'($urandom_range(0, 254)));
      put16(jcmp_pkg::M_SOD);
      put_random(d);
      if ($urandom_range(0, 3) == 0) put16(jcmp_pkg::M_EPH);
    end
    put16(jcmp_pkg::M_EOC);
  endtask

  // Broken ending: one error kind (or endless tile data), then bytes that
  // the halted block must ignore.
  task automatic put_broken_tail();
    int kind;
    kind = $urandom_range(0, 17);
    if (kind >= 4) put16(jcmp_pkg::M_SOC);
    case (kind)
      0: put16({8'($urandom_range(0, 254)), 8'h4f});
      1: put16(16'hff00);
      2: put16(16'hffff);
      3: put16(jcmp_pkg::M_SOT);
      4: begin put16(jcmp_pkg::M_COM); put16(16'($urandom_range(0, 1))); end
      5: begin put16(jcmp_pkg::M_SOT); put16(16'($urandom_range(11, 65535))); end
      6: put_sot(32'($urandom_range(1, 13)), 8'd0);
      7: put_sot(32'd40, 8'hff);
      8: begin put16(jcmp_pkg::M_SIZ); put16(16'($urandom_range(2, 37))); end
      9: put_siz(2, 1);
      10: begin put16(jcmp_pkg::M_COD); put16(16'($urandom_range(2, 11))); end
      11: begin put16(jcmp_pkg::M_QCD); put16(16'd2); end
      12: begin put16(jcmp_pkg::M_TLM); put16(16'($urandom_range(2, 5))); end
      13: put_tlm(3, 1);
      14: begin put16(jcmp_pkg::M_TLM); put16(16'd7); put_random(1);
        stream_q.push_back(8'h00); put_random(3); end
      15: begin put16(jcmp_pkg::M_COM); put16(16'd2); end
      16: begin put_sot(32'd14, 8'd0); put16(jcmp_pkg::M_COM); put16(16'd3); put_random(1);
        put16(jcmp_pkg::M_SOD); end
      default: begin put_sot(32'd0, 8'd0); put16(jcmp_pkg::M_SOD); end
    endcase
    put_random(12);
  endtask

  // Directed opening: SOC, one tile part with two bytes of tile data
  // (extreme byte values), then EOC.
  stim_row_t opening[20] = '{
    '{8'hff, 1, jcmp_pkg::ROLE_MARK_HI, jcmp_pkg::E_NONE},
    '{8'h4f, 1, jcmp_pkg::ROLE_MARK_LO, jcmp_pkg::E_NONE},
    '{8'hff, 1, jcmp_pkg::ROLE_MARK_HI, jcmp_pkg::E_NONE},
    '{8'h90, 1, jcmp_pkg::ROLE_MARK_LO, jcmp_pkg::E_NONE},
    '{8'h00, 1, jcmp_pkg::ROLE_LENGTH, jcmp_pkg::E_NONE},
    '{8'h0a, 1, jcmp_pkg::ROLE_LENGTH, jcmp_pkg::E_NONE},
    '{8'h00, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'h00, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'h00, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'h00, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'h00, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'h10, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'hfe, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'hff, 0, jcmp_pkg::ROLE_BODY, jcmp_pkg::E_NONE},
    '{8'hff, 1, jcmp_pkg::ROLE_MARK_HI, jcmp_pkg::E_NONE},
    '{8'h93, 1, jcmp_pkg::ROLE_MARK_LO, jcmp_pkg::E_NONE},
    '{8'h00, 1, jcmp_pkg::ROLE_TILE, jcmp_pkg::E_NONE},
    '{8'hff, 1, jcmp_pkg::ROLE_TILE, jcmp_pkg::E_NONE},
    '{8'hff, 1, jcmp_pkg::ROLE_MARK_HI, jcmp_pkg::E_NONE},
    '{8'hd9, 1, jcmp_pkg::ROLE_MARK_LO, jcmp_pkg::E_NONE}
  };

  // ---- sender ----------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  initial begin
    int total;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    ph = jcmp_pkg::PH_MARK_HI;
    cur_marker = '0; seg_len = '0; body_pos = '0; tile_parts = '0;
    field_sh = '0; psot = '0; since_sot = '0; skip_left = '0; frames = '0;
    tlm_phase = '0; need_soc = 1'b1; err_latch = jcmp_pkg::E_NONE;

    foreach (opening[i]) begin
      stream_q.push_back(opening[i].data);
      label_q.push_back('{opening[i].typed, opening[i].role, opening[i].err});
    end
    while (stream_q.size() < 500) put_frame();
    put_broken_tail();
    total = stream_q.size();
    while (label_q.size() < total)
      label_q.push_back('{0, jcmp_pkg::ROLE_MARK_HI, jcmp_pkg::E_NONE});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idling mix: receiver sparse first, then sender sparse, then full rate
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        tx_idle = 88; rx_idle = 14;
      end else if (i == 2 * total / 3) begin
        tx_idle = 0; rx_idle = 0;
      end
      send_byte(stream_q[i]);
    end
    in_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---- receiver, predictor hookup, checker, watchdog --------------------------

  always @(posedge clk) begin
    if (rst_n) out_if.ready <= ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk) begin
    jcmp_pkg::result_t exp_r;
    label_t lb;
    if (rst_n && in_if.valid && in_if.ready) begin
      exp_r = label_byte(in_if.data_byte);
      lb = label_q.pop_front();
      if (lb.typed) begin
        exp_r.byte_role = lb.role;
        exp_r.error_code = lb.err;
      end
      expected_q.push_back(exp_r);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.byte_role !== exp_r.byte_role ||
            out_if.marker_code !== exp_r.marker_code ||
            out_if.error_code !== exp_r.error_code ||
            out_if.frame_end !== exp_r.frame_end ||
            out_if.frame_total !== exp_r.frame_total ||
            out_if.tile_part_number !== exp_r.tile_part_number) begin
          $display("%0t: mismatch expected role %0d marker %h err %0d end %0d frames %0d tp %0d",
                   $time, exp_r.byte_role, exp_r.marker_code, exp_r.error_code,
                   exp_r.frame_end, exp_r.frame_total, exp_r.tile_part_number);
          $display("%0t:          actual   role %0d marker %h err %0d end %0d frames %0d tp %0d",
                   $time, out_if.byte_role, out_if.marker_code, out_if.error_code,
                   out_if.frame_end, out_if.frame_total, out_if.tile_part_number);
          fail_count++;
        end
      end
    end
  end

  // Hold a count of cycles with no beat on either side; drop out on a hang.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ j2k_codestream_marker_parser.f @@
src/jcmp_pkg.sv
src/jcmp_byte_if.sv
src/jcmp_result_if.sv
src/jcmp_parse_core.sv
src/j2k_codestream_marker_parser.sv
verif/tb.sv
